FILE: src/hq_pkg.sv
// shared constants for the binary max-heap priority queue
// status codes and parameter defaults; no dependencies
package hq_pkg;

	localparam int DEF_CAPACITY = 16;
	localparam int DEF_KEY_BITS = 16;
	localparam int STATUS_W     = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_REMOVE = 1'b1
	} req_kind_t;

endpackage

FILE: src/hq_req_if.sv
// request channel of the heap queue: valid/ready plus request payload
// depends on hq_pkg for the default key width
interface hq_req_if #(
	parameter int KEY_BITS = hq_pkg::DEF_KEY_BITS
);
	logic                valid;
	logic                ready;
	logic                req_type;
	logic [KEY_BITS-1:0] key_value;

	modport source (output valid, output req_type, output key_value, input ready);
	modport sink   (input valid, input req_type, input key_value, output ready);
endinterface

FILE: src/hq_rsp_if.sv
// response channel of the heap queue: valid/ready plus result payload
// depends on hq_pkg for status width and defaults
interface hq_rsp_if #(
	parameter int CAPACITY = hq_pkg::DEF_CAPACITY,
	parameter int KEY_BITS = hq_pkg::DEF_KEY_BITS,
	localparam int CNT_W   = $clog2(CAPACITY + 1)
);
	logic                        valid;
	logic                        ready;
	logic [hq_pkg::STATUS_W-1:0] status;
	logic [KEY_BITS-1:0]         top_key;
	logic [CNT_W-1:0]            entry_count_out;

	modport source (output valid, output status, output top_key, output entry_count_out,
		input ready);
	modport sink   (input valid, input status, input top_key, input entry_count_out,
		output ready);
endinterface

FILE: src/hq_ram.sv
// key store of the heap queue: one write port, one read port, registered read
// no dependencies
module hq_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 16,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: src/binary_max_heap_queue.sv
// Binary max-heap priority queue. Keys live in a single-port-read key memory
// (hq_ram); the moving key is held in a register and the heap is repaired with
// a hole walk. An insert moves the key up one level at a time until it stays in
// its slot; an insert into an empty heap writes the key straight to the root.
// A remove reads the top and then the last entry; when at most one key remains
// the last entry is written to the root, otherwise it sinks level by level,
// and each level needs two reads (left and right child) through the one read
// port, one where only a left child exists. A refused request goes straight to
// the done state.
// The result register lets a finished result wait while the next item starts.
// Depends on hq_pkg, hq_req_if, hq_rsp_if and hq_ram.
module binary_max_heap_queue #(
	parameter int CAPACITY = hq_pkg::DEF_CAPACITY,
	parameter int KEY_BITS = hq_pkg::DEF_KEY_BITS
) (
	input logic     clk,
	input logic     arst_n,
	hq_req_if.sink  req,
	hq_rsp_if.source rsp
);
	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_UP   = 8'b0000_0010,
		S_FIN  = 8'b0000_0100,
		S_TOP  = 8'b0000_1000,
		S_LAST = 8'b0001_0000,
		S_DNL  = 8'b0010_0000,
		S_DNR  = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	state_t                      state_q, state_n;
	logic [CNT_W-1:0]            count_q, count_n;
	logic [ADDR_W-1:0]           pos_q, pos_n;
	logic [ADDR_W-1:0]           lc_q, lc_n;
	logic [KEY_BITS-1:0]         key_q, key_n;
	logic [KEY_BITS-1:0]         lkey_q, lkey_n;
	logic [KEY_BITS-1:0]         top_q, top_n;
	hq_pkg::status_t             status_q, status_n;

	logic                        rsp_valid_q;
	logic [hq_pkg::STATUS_W-1:0] rsp_status_q;
	logic [KEY_BITS-1:0]         rsp_top_q;
	logic [CNT_W-1:0]            rsp_cnt_q;

	logic                        mem_we;
	logic [ADDR_W-1:0]           mem_waddr;
	logic [KEY_BITS-1:0]         mem_wdata;
	logic [ADDR_W-1:0]           mem_raddr;
	logic [KEY_BITS-1:0]         mem_rdata;

	logic                        req_acc;
	logic                        rsp_load;
	logic [ADDR_W-1:0]           ins_par;
	logic [ADDR_W-1:0]           par;
	logic [ADDR_W-1:0]           grand;
	logic [CNT_W-1:0]            rc_w;
	logic                        right_big;
	logic [ADDR_W-1:0]           big_idx;
	logic [KEY_BITS-1:0]         big_key;
	logic [ADDR_W:0]             nlc;
	logic                        nlc_out;

	hq_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (KEY_BITS)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign rsp_load  = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	// index arithmetic for the hole walk
	assign ins_par   = ADDR_W'((count_q - 1'b1) >> 1);
	assign par       = ADDR_W'((pos_q - 1'b1) >> 1);
	assign grand     = ADDR_W'((par - 1'b1) >> 1);
	assign rc_w      = CNT_W'(lc_q) + 1'b1;
	assign right_big = mem_rdata > lkey_q;
	assign big_idx   = right_big ? ADDR_W'(lc_q + 1'b1) : lc_q;
	assign big_key   = right_big ? mem_rdata : lkey_q;
	assign nlc       = {big_idx, 1'b1};
	assign nlc_out   = (CNT_W + 1)'(nlc) >= (CNT_W + 1)'(count_q);

	always_comb begin
		state_n   = state_q;
		count_n   = count_q;
		pos_n     = pos_q;
		lc_n      = lc_q;
		key_n     = key_q;
		lkey_n    = lkey_q;
		top_n     = top_q;
		status_n  = status_q;
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = key_q;
		mem_raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					top_n    = '0;
					status_n = hq_pkg::ST_OK;
					if (req.req_type == hq_pkg::REQ_INSERT) begin
						if (count_q == CNT_W'(CAPACITY)) begin
							status_n = hq_pkg::ST_FULL;
							state_n  = S_DONE;
						end else begin
							key_n   = req.key_value;
							pos_n   = count_q[ADDR_W-1:0];
							count_n = CNT_W'(count_q + 1'b1);
							if (count_q == '0) begin
								mem_we    = 1'b1;
								mem_waddr = '0;
								mem_wdata = req.key_value;
								state_n   = S_DONE;
							end else begin
								mem_raddr = ins_par;
								state_n   = S_UP;
							end
						end
					end else begin
						if (count_q == '0) begin
							status_n = hq_pkg::ST_EMPTY;
							state_n  = S_DONE;
						end else begin
							count_n   = CNT_W'(count_q - 1'b1);
							mem_raddr = '0;
							state_n   = S_TOP;
						end
					end
				end
			end
			S_UP: begin
				mem_we = 1'b1;
				if (mem_rdata < key_q) begin
					mem_wdata = mem_rdata;
					pos_n     = par;
					if (par == '0) begin
						state_n = S_FIN;
					end else begin
						mem_raddr = grand;
					end
				end else begin
					state_n = S_DONE;
				end
			end
			S_FIN: begin
				mem_we  = 1'b1;
				state_n = S_DONE;
			end
			S_TOP: begin
				top_n     = mem_rdata;
				mem_raddr = count_q[ADDR_W-1:0];
				state_n   = S_LAST;
			end
			S_LAST: begin
				key_n = mem_rdata;
				pos_n = '0;
				if (count_q <= CNT_W'(1)) begin
					mem_we    = 1'b1;
					mem_waddr = '0;
					mem_wdata = mem_rdata;
					state_n   = S_DONE;
				end else begin
					lc_n      = ADDR_W'(1);
					mem_raddr = ADDR_W'(1);
					state_n   = S_DNL;
				end
			end
			S_DNL: begin
				lkey_n = mem_rdata;
				if (rc_w < count_q) begin
					mem_raddr = ADDR_W'(lc_q + 1'b1);
					state_n   = S_DNR;
				end else if (key_q < mem_rdata) begin
					mem_we    = 1'b1;
					mem_wdata = mem_rdata;
					pos_n     = lc_q;
					state_n   = S_FIN;
				end else begin
					mem_we  = 1'b1;
					state_n = S_DONE;
				end
			end
			S_DNR: begin
				mem_we = 1'b1;
				if (key_q < big_key) begin
					mem_wdata = big_key;
					pos_n     = big_idx;
					if (nlc_out) begin
						state_n = S_FIN;
					end else begin
						lc_n      = nlc[ADDR_W-1:0];
						mem_raddr = nlc[ADDR_W-1:0];
						state_n   = S_DNL;
					end
				end else begin
					state_n = S_DONE;
				end
			end
			S_DONE: begin
				if (rsp_load) begin
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			count_q <= count_n;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q    <= pos_n;
		lc_q     <= lc_n;
		key_q    <= key_n;
		lkey_q   <= lkey_n;
		top_q    <= top_n;
		status_q <= status_n;
		if (rsp_load) begin
			rsp_status_q <= status_q;
			rsp_top_q    <= top_q;
			rsp_cnt_q    <= count_q;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = rsp_status_q;
	assign rsp.top_key         = rsp_top_q;
	assign rsp.entry_count_out = rsp_cnt_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_full_refused: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && req.req_type == hq_pkg::REQ_INSERT && count_q == CNT_W'(CAPACITY)
		|=> state_q == S_DONE && status_q == hq_pkg::ST_FULL && $stable(count_q))
		else $error("insert into full heap not refused");

	a_empty_refused: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && req.req_type == hq_pkg::REQ_REMOVE && count_q == '0
		|=> state_q == S_DONE && status_q == hq_pkg::ST_EMPTY && top_q == '0)
		else $error("remove from empty heap not refused");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> CNT_W'(mem_waddr) < CNT_W'(CAPACITY))
		else $error("key memory write beyond capacity");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q) == S_DONE)
		else $error("result raised outside the done state");
endmodule

FILE: verif/tb.sv
// self-checking testbench for binary_max_heap_queue: random insert/remove traffic
// against an in-bench heap predictor, with bursty requests and stalled results
// depends on hq_pkg, hq_req_if, hq_rsp_if and the heap queue rtl
`timescale 1ns / 100ps

module tb;
	localparam int CAPACITY = hq_pkg::DEF_CAPACITY;
	localparam int KEY_BITS = hq_pkg::DEF_KEY_BITS;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int TAIL_CYC = 2 * $clog2(CAPACITY) + 12;
	localparam int N_RANDOM = 500;

	typedef struct packed {
		logic                drain;
		hq_pkg::req_kind_t   kind;
		logic [KEY_BITS-1:0] key;
	} heap_req_t;

	typedef struct packed {
		hq_pkg::status_t     status;
		logic [KEY_BITS-1:0] top_key;
		logic [CNT_W-1:0]    count;
	} heap_result_t;

	logic clk = 1'b0;
	logic arst_n;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	hq_req_if #(.KEY_BITS(KEY_BITS)) req_if ();
	hq_rsp_if #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) rsp_if ();

	binary_max_heap_queue #(
		.CAPACITY(CAPACITY),
		.KEY_BITS(KEY_BITS)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	heap_req_t    pending_q[$];
	heap_result_t expected_q[$];
	int           fail_cnt = 0;

	// predictor state
	logic [KEY_BITS-1:0] heap_keys [CAPACITY];
	int                  heap_held = 0;

	function automatic heap_result_t apply_request(hq_pkg::req_kind_t kind,
		logic [KEY_BITS-1:0] key);
		heap_result_t        r;
		int                  pos;
		int                  lc;
		int                  big;
		logic                sinking;
		logic [KEY_BITS-1:0] t;
		r.status  = hq_pkg::ST_OK;
		r.top_key = '0;
		if (kind == hq_pkg::REQ_INSERT) begin
			if (heap_held >= CAPACITY) begin
				r.status = hq_pkg::ST_FULL;
			end else begin
				heap_keys[heap_held] = key;
				pos = heap_held;
				while (pos > 0 && heap_keys[(pos - 1) / 2] < heap_keys[pos]) begin
					t = heap_keys[pos];
					heap_keys[pos] = heap_keys[(pos - 1) / 2];
					heap_keys[(pos - 1) / 2] = t;
					pos = (pos - 1) / 2;
				end
				heap_held++;
			end
		end else begin
			if (heap_held == 0) begin
				r.status = hq_pkg::ST_EMPTY;
			end else begin
				r.top_key = heap_keys[0];
				heap_held--;
				heap_keys[0] = heap_keys[heap_held];
				pos = 0;
				sinking = 1'b1;
				while (sinking) begin
					lc = 2 * pos + 1;
					if (lc >= heap_held) begin
						sinking = 1'b0;
					end else begin
						big = lc;
						if (lc + 1 < heap_held && heap_keys[lc + 1] > heap_keys[lc])
							big = lc + 1;
						if (heap_keys[pos] < heap_keys[big]) begin
							t = heap_keys[pos];
							heap_keys[pos] = heap_keys[big];
							heap_keys[big] = t;
							pos = big;
						end else begin
							sinking = 1'b0;
						end
					end
				end
			end
		end
		r.count = CNT_W'(heap_held);
		return r;
	endfunction

	// request driver
	heap_req_t cur_req;
	int        burst_left;
	int        gap_left;

	always @(posedge clk or negedge arst_n) begin
		logic send;
		if (!arst_n) begin
			req_if.valid     <= 1'b0;
			req_if.req_type  <= hq_pkg::REQ_INSERT;
			req_if.key_value <= '0;
			burst_left = 1;
			gap_left   = 0;
		end else begin
			if (req_if.valid && req_if.ready)
				expected_q.push_back(apply_request(cur_req.kind, cur_req.key));
			if (!(req_if.valid && !req_if.ready)) begin
				send = 1'b0;
				if (pending_q.size() > 0 && pending_q[0].drain && expected_q.size() == 0)
					void'(pending_q.pop_front());
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_q.size() > 0 && !pending_q[0].drain) begin
					cur_req = pending_q.pop_front();
					send = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
				req_if.valid <= send;
				if (send) begin
					req_if.req_type  <= cur_req.kind;
					req_if.key_value <= cur_req.key;
				end
			end
		end
	end

	// result monitor and stall pattern
	int          stall_mode;
	int          mode_cyc;
	logic [15:0] stall_pat;

	always @(posedge clk or negedge arst_n) begin
		heap_result_t exp_r;
		logic         rdy;
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			stall_mode = 0;
			mode_cyc   = 0;
			stall_pat  = 16'hB35D;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (expected_q.size() == 0) begin
					$error("result with no request pending: status %0d top_key %0h count %0d",
						rsp_if.status, rsp_if.top_key, rsp_if.entry_count_out);
					fail_cnt++;
				end else begin
					exp_r = expected_q.pop_front();
					if (rsp_if.status !== exp_r.status) begin
						$error("status: expected %0d, got %0d", exp_r.status, rsp_if.status);
						fail_cnt++;
					end
					if (rsp_if.top_key !== exp_r.top_key) begin
						$error("top_key: expected %0h, got %0h", exp_r.top_key, rsp_if.top_key);
						fail_cnt++;
					end
					if (rsp_if.entry_count_out !== exp_r.count) begin
						$error("entry_count_out: expected %0d, got %0d",
							exp_r.count, rsp_if.entry_count_out);
						fail_cnt++;
					end
				end
			end
			mode_cyc++;
			if (mode_cyc >= 96) begin
				mode_cyc   = 0;
				stall_mode = $urandom_range(0, 3);
				stall_pat  = 16'($urandom);
			end
			stall_pat = {stall_pat[14:0], stall_pat[15]};
			case (stall_mode)
				0: rdy = 1'b1;
				1: rdy = 1'($urandom_range(0, 1));
				2: rdy = ($urandom_range(0, 3) == 0);
				default: rdy = stall_pat[0];
			endcase
			rsp_if.ready <= rdy;
		end
	end

	// stimulus
	int gen_count = 0;
	int n_random  = 0;

	task automatic add_req(hq_pkg::req_kind_t kind, logic [KEY_BITS-1:0] key);
		heap_req_t it;
		it.drain = 1'b0;
		it.kind  = kind;
		it.key   = key;
		pending_q.push_back(it);
		if (kind == hq_pkg::REQ_INSERT && gen_count < CAPACITY)
			gen_count++;
		else if (kind == hq_pkg::REQ_REMOVE && gen_count > 0)
			gen_count--;
	endtask

	task automatic add_drain();
		heap_req_t it;
		it       = '0;
		it.drain = 1'b1;
		pending_q.push_back(it);
	endtask

	function automatic logic [KEY_BITS-1:0] rand_key();
		case ($urandom_range(0, 5))
			0: return KEY_BITS'($urandom_range(0, 7));
			1: return {KEY_BITS{1'b1}} - KEY_BITS'($urandom_range(0, 3));
			2: return '0;
			default: return KEY_BITS'($urandom);
		endcase
	endfunction

	initial begin
		int seg_len;
		int mode;
		arst_n = 1'b0;

		add_req(hq_pkg::REQ_REMOVE, '0);
		add_req(hq_pkg::REQ_INSERT, 16'hFFFF);
		add_req(hq_pkg::REQ_INSERT, 16'h0000);
		add_req(hq_pkg::REQ_INSERT, 16'h8000);
		add_req(hq_pkg::REQ_INSERT, 16'h8000);
		add_req(hq_pkg::REQ_INSERT, 16'h7FFF);
		add_req(hq_pkg::REQ_INSERT, 16'h0001);
		add_req(hq_pkg::REQ_INSERT, 16'h5555);
		add_req(hq_pkg::REQ_INSERT, 16'hAAAA);
		add_req(hq_pkg::REQ_REMOVE, 16'hFFFF);
		for (int i = 0; i < 8; i++)
			add_req(hq_pkg::REQ_REMOVE, 16'h1234);
		add_drain();

		while (n_random < N_RANDOM) begin
			mode = $urandom_range(0, 5);
			if (mode == 4) begin
				while (gen_count < CAPACITY) begin
					add_req(hq_pkg::REQ_INSERT, rand_key());
					n_random++;
				end
				for (int i = $urandom_range(1, 2); i > 0; i--) begin
					add_req(hq_pkg::REQ_INSERT, rand_key());
					n_random++;
				end
			end else if (mode == 5) begin
				while (gen_count > 0) begin
					add_req(hq_pkg::REQ_REMOVE, KEY_BITS'($urandom));
					n_random++;
				end
				for (int i = $urandom_range(1, 2); i > 0; i--) begin
					add_req(hq_pkg::REQ_REMOVE, KEY_BITS'($urandom));
					n_random++;
				end
			end else begin
				seg_len = $urandom_range(5, 40);
				for (int i = 0; i < seg_len; i++) begin
					case (mode)
						0: add_req(($urandom_range(0, 9) < 8) ? hq_pkg::REQ_INSERT
							: hq_pkg::REQ_REMOVE, rand_key());
						1: add_req(($urandom_range(0, 9) < 2) ? hq_pkg::REQ_INSERT
							: hq_pkg::REQ_REMOVE, rand_key());
						default: add_req(hq_pkg::req_kind_t'($urandom_range(0, 1)), rand_key());
					endcase
					n_random++;
				end
			end
			if ($urandom_range(0, 7) == 0)
				add_drain();
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk);
		while (pending_q.size() > 0 || req_if.valid || expected_q.size() > 0);
		repeat (TAIL_CYC) @(posedge clk);

		if (fail_cnt == 0 && expected_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#2ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
